[hw/rtl/assert_macros.svh]
// Assertion macros shared by the line editor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/lgb_pkg.sv]
// Shared constants, codes and control types of the line editor.
`default_nettype none

package lgb_pkg;

    localparam int LINE_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int CNT_W      = ADDR_W + 1;

    localparam int KEY_W      = 8;
    localparam int IDX_W      = 10;
    localparam int CHAR_W     = 8;
    localparam int LEN_W      = 11;

    localparam int IN_USER_W  = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    localparam logic [KEY_W-1:0] KEY_LEFT   = 8'h3C;
    localparam logic [KEY_W-1:0] KEY_RIGHT  = 8'h3E;
    localparam logic [KEY_W-1:0] KEY_DELETE = 8'h2D;

    typedef enum logic [1:0] {
        CMD_KEY   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_MEM,
        ST_PUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the input beat
        logic run;       // decode, insert/delete/clear updates, issue store read
        logic mem;       // store read data back: finish move or read
        logic put;       // load the output register
    } lgb_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic need_mem;  // item needs a store read
        logic out_busy;  // output register cannot take a beat this cycle
    } lgb_sts_t;

endpackage

`default_nettype wire

[hw/rtl/lgb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/lgb_ctrl.sv]
// Controller state machine of the line editor.
`default_nettype none
`include "assert_macros.svh"

module lgb_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire lgb_pkg::lgb_sts_t sts,
    output lgb_pkg::lgb_ctl_t     ctl
);

    import lgb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                ctl.run    = 1'b1;
                state_next = sts.need_mem ? ST_MEM : ST_PUT;
            end
            ST_MEM:
            begin
                ctl.mem    = 1'b1;
                state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (!sts.out_busy)
                begin
                    ctl.put    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // store read data is only consumed right after it was requested
    `ASSERT_IMPLY(a_mem_after_run, state_reg == ST_MEM, $past(state_reg) == ST_RUN)
    // a result is never loaded over one still waiting
    `ASSERT_IMPLY(a_put_when_free, ctl.put, !sts.out_busy)

endmodule

`default_nettype wire

[hw/rtl/lgb_dp.sv]
// Datapath of the line editor: counts, gap store, input and output registers.
`default_nettype none
`include "assert_macros.svh"

module lgb_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lgb_pkg::lgb_ctl_t                 ctl,
    output lgb_pkg::lgb_sts_t                      sts,
    input  wire logic [lgb_pkg::IN_USER_W-1:0]     s_tuser,
    input  wire logic [lgb_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [lgb_pkg::OUT_DATA_W-1:0]    m_tdata
);

    import lgb_pkg::*;

    cmd_t               cmd_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   left_reg;
    logic [CNT_W-1:0]   left_next;
    logic [CNT_W-1:0]   right_reg;
    logic [CNT_W-1:0]   right_next;
    logic [CHAR_W-1:0]  char_reg;
    logic               rvalid_reg;
    logic               drop_reg;
    logic               m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic [CNT_W-1:0]   len;
    logic [CNT_W-1:0]   gap;
    logic [CNT_W-1:0]   idx_ext;
    logic               is_key;
    logic               mv_left;
    logic               mv_right;
    logic               is_del;
    logic               is_ins;
    logic               full;
    logic               rd_hit;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CHAR_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CHAR_W-1:0]  ram_rdata;

    // ---- decode of the held item ----
    assign len      = left_reg + right_reg;
    assign gap      = CNT_W'(LINE_DEPTH) - len;
    assign idx_ext  = CNT_W'(idx_reg);
    assign full     = (len == CNT_W'(LINE_DEPTH));
    assign is_key   = (cmd_reg == CMD_KEY);
    assign mv_left  = is_key && (key_reg == KEY_LEFT) && (left_reg != '0);
    assign mv_right = is_key && (key_reg == KEY_RIGHT) && (right_reg != '0);
    assign is_del   = is_key && (key_reg == KEY_DELETE);
    assign is_ins   = is_key && (key_reg != KEY_LEFT) && (key_reg != KEY_RIGHT)
                      && (key_reg != KEY_DELETE);
    assign rd_hit   = (cmd_reg == CMD_READ) && (idx_ext < len);

    assign sts.need_mem = mv_left || mv_right || rd_hit;
    assign sts.out_busy = m_tvalid_reg && !m_tready;

    // ---- gap store access ----
    always_comb
    begin
        if (mv_left)
        begin
            ram_raddr = ADDR_W'(left_reg - CNT_W'(1));
        end
        else if (mv_right)
        begin
            ram_raddr = ADDR_W'(CNT_W'(LINE_DEPTH) - right_reg);
        end
        else if (idx_ext < left_reg)
        begin
            ram_raddr = ADDR_W'(idx_ext);
        end
        else
        begin
            ram_raddr = ADDR_W'(idx_ext + gap);
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(left_reg);
        ram_wdata = key_reg;
        if (ctl.run && is_ins && !full)
        begin
            ram_we = 1'b1;
        end
        else if (ctl.mem && is_key)
        begin
            // character crosses the gap
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            if (mv_left)
            begin
                ram_waddr = ADDR_W'(CNT_W'(LINE_DEPTH) - right_reg - CNT_W'(1));
            end
        end
    end

    lgb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ctl.run),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---- counts ----
    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        if (ctl.run)
        begin
            case (cmd_reg)
                CMD_KEY:
                begin
                    if (is_del && (left_reg != '0))
                    begin
                        left_next = left_reg - CNT_W'(1);
                    end
                    else if (is_ins && !full)
                    begin
                        left_next = left_reg + CNT_W'(1);
                    end
                end
                CMD_CLEAR:
                begin
                    left_next  = '0;
                    right_next = '0;
                end
                default:
                begin
                    left_next  = left_reg;
                end
            endcase
        end
        else if (ctl.mem && mv_left)
        begin
            left_next  = left_reg - CNT_W'(1);
            right_next = right_reg + CNT_W'(1);
        end
        else if (ctl.mem && mv_right)
        begin
            left_next  = left_reg + CNT_W'(1);
            right_next = right_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg     <= '0;
            right_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            if (ctl.put)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= cmd_t'(s_tuser);
            key_reg <= s_tdata[KEY_W-1:0];
            idx_reg <= s_tdata[KEY_W +: IDX_W];
        end
        if (ctl.run)
        begin
            char_reg   <= '0;
            rvalid_reg <= rd_hit;
            drop_reg   <= is_ins && full;
        end
        else if (ctl.mem && (cmd_reg == CMD_READ))
        begin
            char_reg <= ram_rdata;
        end
        if (ctl.put)
        begin
            m_tdata_reg <= {drop_reg, LEN_W'(left_reg), LEN_W'(len), rvalid_reg, char_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // the line never outgrows the store
    `ASSERT_IMPLY(a_len_max, 1'b1, ({1'b0, left_reg} + {1'b0, right_reg}) <= (CNT_W + 1)'(LINE_DEPTH))
    // a cursor move only shifts characters across the gap
    `ASSERT_NEXT(a_move_keeps_len, ctl.mem && is_key, $stable(len))

endmodule

`default_nettype wire

[hw/rtl/line_edit_gap_buffer_core.sv]
// Top level of the gap-buffer line editor: controller plus datapath.
// Each beat runs IDLE, RUN, MEM (cursor moves and in-line reads only), then PUT; PUT
// waits while the output is busy. One item at a time: a new beat is taken only after PUT;
//   the registered read of the gap store adds the MEM state.
// Output holds one result; a new beat is taken while it waits downstream.
// Reset (rst_n low, async): empty line, cursor at 0, no result pending; store not cleared.
`default_nettype none

module line_edit_gap_buffer_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input beat
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [1:0] cmd
    input  wire logic [lgb_pkg::IN_USER_W-1:0]      s_axis_tuser,
    // [7:0] key_byte, [17:8] read_index, [23:18] zero
    input  wire logic [lgb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // result beat
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [7:0] read_char, [8] read_valid, [19:9] line_length, [30:20] cursor_pos,
    // [31] dropped
    output logic      [lgb_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    import lgb_pkg::*;

    lgb_ctl_t ctl;
    lgb_sts_t sts;

    // Sequencer: IDLE takes a beat, RUN decodes and issues the store read,
    // MEM finishes a move or read, PUT hands the result to the output register.
    lgb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Counts, gap store and the registered result.
    lgb_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .sts      (sts),
        .s_tuser  (s_axis_tuser),
        .s_tdata  (s_axis_tdata),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire
